// ===== design/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 message hasher.
// No dependencies; imported by every module of the block.
package sha256_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BYTES_W      = 3;
    localparam logic [31:0] MAX_MSG_BYTES = 32'h7FFF_FFFF;
    localparam logic [7:0]  PAD_BYTE      = 8'h80;
    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;

    // Class of a queued word
    typedef enum logic [1:0] {
        CLS_DATA      = 2'd0,   // ordinary message word
        CLS_LAST_FULL = 2'd1,   // last word, four bytes, pad word still owed
        CLS_LAST_PART = 2'd2    // last word, pad byte already merged in
    } sha256_cls_t;

    typedef struct packed {
        logic [31:0]  word;
        sha256_cls_t  cls;
        logic [31:0]  byte_count;   // running count, valid on last word
        logic         overflow;     // valid on last word
    } sha256_entry_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== design/sha256_front.sv =====
// Front end: takes message words, counts bytes, merges the pad byte into a
// short last word and tags each word for the back end. Uses sha256_pkg.
module sha256_front
    import sha256_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [31:0]   data_word,
    input  logic [2:0]    bytes_valid,
    input  logic          last_word,
    output logic          q_valid,
    input  logic          q_ready,
    output sha256_entry_t q_entry
);

    logic [31:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [2:0]  nvalid;
    logic [2:0]  add_bytes;
    logic [31:0] sum;
    logic [31:0] word;
    logic        accept;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign accept   = in_valid & q_ready;

    // oversized byte counts act as a full word
    assign nvalid    = (bytes_valid > FULL_WORD_BYTES) ? FULL_WORD_BYTES : bytes_valid;
    assign add_bytes = last_word ? nvalid : FULL_WORD_BYTES;
    assign sum       = count_reg + {29'b0, add_bytes};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (!ovf_reg)
        begin
            count_next = sum;
            ovf_next   = (sum > MAX_MSG_BYTES);
        end
    end

    always_comb
    begin
        case (nvalid)
            3'd0:    word = {PAD_BYTE, 24'h0};
            3'd1:    word = {data_word[31:24], PAD_BYTE, 16'h0};
            3'd2:    word = {data_word[31:16], PAD_BYTE, 8'h0};
            3'd3:    word = {data_word[31:8], PAD_BYTE};
            default: word = data_word;
        endcase
    end

    always_comb
    begin
        q_entry.byte_count = count_next;
        q_entry.overflow   = ovf_next;
        if (!last_word)
        begin
            q_entry.word = data_word;
            q_entry.cls  = CLS_DATA;
        end
        else if (nvalid == FULL_WORD_BYTES)
        begin
            q_entry.word = data_word;
            q_entry.cls  = CLS_LAST_FULL;
        end
        else
        begin
            q_entry.word = word;
            q_entry.cls  = CLS_LAST_PART;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_word)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// ===== design/sha256_queue.sv =====
// Small register FIFO between front and back end.
// Uses sha256_pkg for the entry type.
module sha256_queue
    import sha256_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sha256_entry_t push_entry,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sha256_entry_t pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sha256_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic                do_push, do_pop;

    assign push_ready = (fill_reg != FULL_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

// ===== design/sha256_core.sv =====
// Back end: block window, padding sequencer, one-round-per-cycle compression,
// chaining state and the digest output register. Uses sha256_pkg.
module sha256_core
    import sha256_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  sha256_entry_t q_entry,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   digest_part_0,
    output logic [63:0]   digest_part_1,
    output logic [63:0]   digest_part_2,
    output logic [63:0]   digest_part_3,
    output logic          too_long
);

    typedef enum logic [3:0] {
        ST_ABSORB = 4'b0001,
        ST_PAD    = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_FINAL  = 4'b1000
    } core_state_t;

    core_state_t state_reg, state_next;
    core_state_t ret_reg, ret_next;
    logic [3:0]  words_reg, words_next;
    logic [5:0]  round_reg, round_next;
    logic        pend80_reg, pend80_next;
    logic        hi_done_reg, hi_done_next;
    logic        final_reg, final_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] count_reg, count_next;

    logic [31:0] win_reg   [16];
    logic [31:0] var_reg   [8];
    logic [31:0] var_next  [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next[8];
    logic [31:0] sum_w     [8];

    logic        out_valid_reg, out_valid_next;
    logic [63:0] dig_reg [4];
    logic        too_long_reg;
    logic        out_load;

    logic        push_en, shift_en, load_vars, chain_wr, out_busy;
    logic [31:0] push_word, shift_in, sched_w, t1, t2;
    logic [31:0] len_hi, len_lo;

    assign q_ready   = (state_reg == ST_ABSORB);
    assign out_busy  = out_valid_reg & ~out_ready;
    assign len_hi    = {29'b0, count_reg[31:29]};
    assign len_lo    = {count_reg[28:0], 3'b000};

    assign sched_w = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
                   + small_sigma1(win_reg[14]);
    assign t1 = var_reg[7] + big_sigma1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + ROUND_K[round_reg] + win_reg[0];
    assign t2 = big_sigma0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            sum_w[i] = chain_reg[i] + var_reg[i];
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        words_next   = words_reg;
        round_next   = round_reg;
        pend80_next  = pend80_reg;
        hi_done_next = hi_done_reg;
        final_next   = final_reg;
        ovf_next     = ovf_reg;
        count_next   = count_reg;
        push_en      = 1'b0;
        push_word    = '0;
        load_vars    = 1'b0;
        chain_wr     = 1'b0;
        out_load     = 1'b0;
        chain_next   = sum_w;
        for (int i = 0; i < 8; i++)
            var_next[i] = var_reg[i];

        case (state_reg)
            ST_ABSORB:
            begin
                if (q_valid)
                begin
                    push_en   = 1'b1;
                    push_word = q_entry.word;
                    if (q_entry.cls != CLS_DATA)
                    begin
                        count_next  = q_entry.byte_count;
                        ovf_next    = q_entry.overflow;
                        pend80_next = (q_entry.cls == CLS_LAST_FULL);
                        state_next  = ST_PAD;
                    end
                    if (words_reg == 4'd15)
                    begin
                        load_vars  = 1'b1;
                        ret_next   = (q_entry.cls == CLS_DATA) ? ST_ABSORB : ST_PAD;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (pend80_reg)
                begin
                    push_word   = {PAD_BYTE, 24'h0};
                    pend80_next = 1'b0;
                end
                else if (hi_done_reg)
                begin
                    push_word  = len_lo;
                    final_next = 1'b1;
                end
                else if (words_reg == 4'd14)
                begin
                    push_word    = len_hi;
                    hi_done_next = 1'b1;
                end
                if (words_reg == 4'd15)
                begin
                    load_vars  = 1'b1;
                    ret_next   = ST_PAD;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                round_next  = round_reg + 1'b1;
                if (round_reg == 6'd63)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (!final_reg)
                begin
                    chain_wr   = 1'b1;
                    state_next = ret_reg;
                end
                else if (!out_busy)
                begin
                    // digest out, then back to the reset state
                    out_load     = 1'b1;
                    chain_wr     = 1'b1;
                    chain_next   = IV;
                    pend80_next  = 1'b0;
                    hi_done_next = 1'b0;
                    final_next   = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = ST_ABSORB;
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase

        if (push_en)
            words_next = words_reg + 1'b1;
        if (load_vars)
            var_next = chain_reg;
    end

    assign shift_en = push_en | (state_reg == ST_ROUND);
    assign shift_in = push_en ? push_word : sched_w;

    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= shift_in;
        end
        for (int i = 0; i < 8; i++)
            var_reg[i] <= var_next[i];
        count_reg <= count_next;
        if (out_load)
        begin
            for (int i = 0; i < 4; i++)
                dig_reg[i] <= ovf_reg ? 64'h0 : {sum_w[2 * i], sum_w[2 * i + 1]};
            too_long_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABSORB;
            ret_reg       <= ST_ABSORB;
            words_reg     <= '0;
            round_reg     <= '0;
            pend80_reg    <= 1'b0;
            hi_done_reg   <= 1'b0;
            final_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= IV;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            words_reg     <= words_next;
            round_reg     <= round_next;
            pend80_reg    <= pend80_next;
            hi_done_reg   <= hi_done_next;
            final_reg     <= final_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (chain_wr)
                chain_reg <= chain_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign digest_part_0 = dig_reg[0];
    assign digest_part_1 = dig_reg[1];
    assign digest_part_2 = dig_reg[2];
    assign digest_part_3 = dig_reg[3];
    assign too_long      = too_long_reg;

    // compression always starts on a full block
    a_round_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (words_reg == 4'd0))
        else $error("compression running on a partial block");

    // round counter is idle outside the rounds
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter out of step with state");

    // a finished digest waits while the output register is held
    a_final_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL && final_reg && out_busy) |=> (state_reg == ST_FINAL))
        else $error("digest dropped while output stalled");

    // after a digest the chaining state is back at the initial values
    a_chain_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (chain_reg[0] == IV[0] && chain_reg[7] == IV[7]
                      && words_reg == 4'd0 && out_valid_reg))
        else $error("state not restored after digest");

endmodule

// ===== design/sha256_message_hasher.sv =====
// SHA-256 message hasher, top level: front end, word queue and back end.
// Each block is absorbed word by word into the block window, then compressed by the
// single compression datapath, one round per cycle, and added into the chaining state;
// the back end takes no new words while a block is being compressed.
// Reset (rst_n low, asynchronous): queue empty, counters clear, chain at the IV.
// No clearing pass is needed; the block window is always filled before use.
module sha256_message_hasher
    import sha256_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  bytes_valid,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_part_0,
    output logic [63:0] digest_part_1,
    output logic [63:0] digest_part_2,
    output logic [63:0] digest_part_3,
    output logic        too_long
);

    // front end -> queue
    logic          fq_valid, fq_ready;
    sha256_entry_t fq_entry;
    // queue -> back end
    logic          qb_valid, qb_ready;
    sha256_entry_t qb_entry;

    // Front end classifies each transfer: plain word, full last word (pad
    // word owed) or short last word (pad byte merged). It also keeps the
    // byte count and the too-long flag, which travel with the last word.
    sha256_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .bytes_valid (bytes_valid),
        .last_word   (last_word),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_entry     (fq_entry)
    );

    // Queue lets input transfers continue while the back end runs rounds.
    sha256_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_entry (fq_entry),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_entry  (qb_entry)
    );

    // Back end takes words only between compressions, generates the
    // remaining pad and length words itself, and holds the digest in an
    // output register so the next message can start while it waits.
    sha256_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_entry       (qb_entry),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digest_part_0 (digest_part_0),
        .digest_part_1 (digest_part_1),
        .digest_part_2 (digest_part_2),
        .digest_part_3 (digest_part_3),
        .too_long      (too_long)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sha256_message_hasher: a directed table of words,
// then random messages; each digest is held to an in-bench SHA-256 model or a typed one.
// Depends on sha256_pkg and the block's design files under design/.
module testbench;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_WORDS  = 1950;
    localparam int HOLD_AFTER    = 300;    // words accepted before the long output hold
    localparam int HOLD_CYCLES   = 3000;
    localparam int DRAIN_CYCLES  = 400;    // well over the longest digest latency
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 25_000_000;

    localparam logic [31:0] MAX_BYTES  = 32'h7fff_ffff;
    localparam logic [2:0]  WORD_BYTES = 3'd4;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;

    // Well-known digests: empty message and "abc"
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [63:0] part0;
        logic [63:0] part1;
        logic [63:0] part2;
        logic [63:0] part3;
        logic        too_long;
    } digest_t;

    // One row of stimulus; known rows carry a digest typed in by hand
    typedef struct packed {
        logic [31:0]  word;
        logic [2:0]   nbytes;
        logic         last;
        logic         known;
        logic [255:0] digest;
    } hash_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_part_0;
    logic [63:0] digest_part_1;
    logic [63:0] digest_part_2;
    logic [63:0] digest_part_3;
    logic        too_long;

    // Side-band travelling with the payload, so the scoreboard knows a hand-typed row
    logic         row_known;
    logic [255:0] row_digest;

    hash_word_t stim_q[$];
    digest_t    digest_q[$];
    int         error_count    = 0;
    int         accepted_words = 0;
    bit         calm_phase     = 1'b0;

    // Predictor state: chaining words, block window, fill level, byte count
    logic [31:0] chain_h [8];
    logic [31:0] block_w [16];
    int unsigned fill_words;
    logic [31:0] msg_bytes;
    logic        len_over;

    sha256_message_hasher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_word     (data_word),
        .bytes_valid   (bytes_valid),
        .last_word     (last_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digest_part_0 (digest_part_0),
        .digest_part_1 (digest_part_1),
        .digest_part_2 (digest_part_2),
        .digest_part_3 (digest_part_3),
        .too_long      (too_long)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hasher_clear();
        for (int i = 0; i < 8; i++)
            chain_h[i] = SHA_IV[i];
        fill_words = 0;
        msg_bytes  = '0;
        len_over   = 1'b0;
    endtask

    // 64-round compression of the block window into the chaining words
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = block_w[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int t = 0; t < 8; t++)
            v[t] = chain_h[t];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            chain_h[t] = chain_h[t] + v[t];
    endtask

    task automatic absorb_word(input logic [31:0] word);
        block_w[fill_words] = word;
        fill_words++;
        if (fill_words == 16)
        begin
            compress_block();
            fill_words = 0;
        end
    endtask

    // Byte count saturates once it has gone past the limit
    task automatic count_bytes(input logic [31:0] n);
        if (!len_over)
        begin
            msg_bytes = msg_bytes + n;
            if (msg_bytes > MAX_BYTES)
                len_over = 1'b1;
        end
    endtask

    // Advance the model by one accepted word; on a last word, pad and give the digest
    task automatic hash_word(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last, output bit done, output digest_t dig);
        int unsigned nb;
        logic [31:0] keep;
        logic [63:0] bit_len;
        done = 1'b0;
        dig  = '0;
        if (!last)
        begin
            // mid-message words always count as four bytes
            count_bytes(32'd4);
            absorb_word(word);
        end
        else
        begin
            nb = (nbytes > WORD_BYTES) ? WORD_BYTES : nbytes;
            count_bytes(nb);
            if (nb == WORD_BYTES)
            begin
                absorb_word(word);
                absorb_word(PAD_WORD);
            end
            else
            begin
                keep = ~(32'hffff_ffff >> (8 * nb));
                absorb_word((word & keep) | (PAD_WORD >> (8 * nb)));
            end
            // no room for the length: finish this block with zeros
            if (fill_words > 14)
                while (fill_words != 0)
                    absorb_word(32'd0);
            while (fill_words < 14)
                absorb_word(32'd0);
            bit_len = {32'd0, msg_bytes} << 3;
            absorb_word(bit_len[63:32]);
            absorb_word(bit_len[31:0]);
            done = 1'b1;
            if (len_over)
                dig = {256'd0, 1'b1};
            else
                dig = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                       chain_h[4], chain_h[5], chain_h[6], chain_h[7], 1'b0};
            hasher_clear();
        end
    endtask

    task automatic add_row(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic last, input logic known, input logic [255:0] digest);
        stim_q.push_back('{word, nbytes, last, known, digest});
    endtask

    function automatic logic [31:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Mostly back-to-back, often a short pause, now and then a long one
    function automatic int unsigned idle_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch: %s", what);
    endtask

    // Scoreboard: predict on each input transfer, check on each output transfer.
    // Handshakes are sampled at the edge, before this edge's updates land.
    always @(posedge clk)
    begin : scoreboard
        bit      produced;
        digest_t predicted;
        digest_t wanted;
        digest_t seen;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                hash_word(data_word, bytes_valid, last_word, produced, predicted);
                accepted_words++;
                if (produced)
                begin
                    if (row_known)
                        digest_q.push_back(digest_t'({row_digest, 1'b0}));
                    else
                        digest_q.push_back(predicted);
                end
            end
            if (out_valid && out_ready)
            begin
                seen = {digest_part_0, digest_part_1, digest_part_2, digest_part_3, too_long};
                if (digest_q.size() == 0)
                    flag_error($sformatf("digest with nothing expected: %h", seen));
                else
                begin
                    wanted = digest_q.pop_front();
                    if (seen.part0 !== wanted.part0)
                        flag_error($sformatf("digest_part_0 expected %h got %h",
                                             wanted.part0, seen.part0));
                    if (seen.part1 !== wanted.part1)
                        flag_error($sformatf("digest_part_1 expected %h got %h",
                                             wanted.part1, seen.part1));
                    if (seen.part2 !== wanted.part2)
                        flag_error($sformatf("digest_part_2 expected %h got %h",
                                             wanted.part2, seen.part2));
                    if (seen.part3 !== wanted.part3)
                        flag_error($sformatf("digest_part_3 expected %h got %h",
                                             wanted.part3, seen.part3));
                    if (seen.too_long !== wanted.too_long)
                        flag_error($sformatf("too_long expected %b got %b",
                                             wanted.too_long, seen.too_long));
                end
            end
        end
    end

    // Receiver: random ready pattern, with one long hold-off once the input is busy,
    // so the word queue fills and in_ready drops while the sender keeps offering.
    initial
    begin : receiver
        int unsigned gap;
        bit          held;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && accepted_words >= HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = idle_gap(calm_phase);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("testbench: errors");
        $finish;
    end

    // Sender and run control
    initial
    begin : sender
        int unsigned gap;
        int unsigned body;
        int unsigned r;
        int          random_words;
        hash_word_t  item;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_word   = '0;
        bytes_valid = '0;
        last_word   = 1'b0;
        row_known   = 1'b0;
        row_digest  = '0;
        hasher_clear();

        // Directed rows: word, bytes, last, known, digest
        add_row(32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST);  // empty message
        add_row(32'h6162_6300, 3'd3, 1'b1, 1'b1, ABC_DIGEST);    // "abc"
        add_row(32'hffff_ffff, 3'd1, 1'b0, 1'b0, '0);  // short count mid-message: four bytes
        add_row(32'hffff_ffff, 3'd7, 1'b1, 1'b0, '0);  // oversized count on last word
        add_row(32'h0000_0000, 3'd5, 1'b1, 1'b0, '0);
        add_row(32'hdead_beef, 3'd6, 1'b1, 1'b0, '0);
        add_row(32'h1234_5678, 3'd2, 1'b1, 1'b0, '0);  // unused bytes overwritten by pad
        add_row(32'ha5a5_a5a5, 3'd1, 1'b1, 1'b0, '0);
        add_row(32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0);  // full last word, pad word owed
        // fourteen words: pad word lands in slot 14, length spills into a second block
        for (int k = 0; k < 13; k++)
            add_row((k % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'd4, 1'b0, 1'b0, '0);
        add_row(32'h0123_4567, 3'd4, 1'b1, 1'b0, '0);

        // Random messages, mostly short, some spanning several blocks
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                body = $urandom_range(0, 20);
            else if (r < 95)
                body = $urandom_range(21, 48);
            else
                body = $urandom_range(49, 80);
            for (int k = 0; k < body; k++)
                add_row(rand_word(),
                        ($urandom_range(0, 9) > 6) ? 3'($urandom_range(0, 7)) : WORD_BYTES,
                        1'b0, 1'b0, '0);
            r = $urandom_range(0, 99);
            add_row(rand_word(),
                    (r < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7)),
                    1'b1, 1'b0, '0);
            random_words += body + 1;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; valid stays up across back-to-back transfers
        for (int i = 0; i < stim_q.size(); i++)
        begin
            item       = stim_q[i];
            calm_phase = (i % 400) >= 340;
            gap        = idle_gap(calm_phase);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid    <= 1'b1;
            data_word   <= item.word;
            bytes_valid <= item.nbytes;
            last_word   <= item.last;
            row_known   <= item.known;
            row_digest  <= item.digest;
            do
                @(posedge clk);
            while (!in_ready);
        end
        in_valid <= 1'b0;

        // Drain: every digest in, then a quiet spell to catch strays
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sha256_pkg.sv
design/sha256_front.sv
design/sha256_queue.sv
design/sha256_core.sv
design/sha256_message_hasher.sv
verif/testbench.sv
